// ===== rtl/psb_pkg.sv =====
// ----------------------------------------------------------------------------
// Pendulum controller package
// Shared constants, widths and codes of the swing-up and balance controller.
// ----------------------------------------------------------------------------
package psb_pkg;

    localparam int RATE_TAPS_DEFAULT = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_UPRIGHT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAL_P     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAL_D     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_P     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_D     = 3'd5;

    localparam logic [11:0] UPRIGHT_RESET = 12'd3100;
    localparam logic [15:0] CENTER_RESET  = 16'd10000;
    localparam logic [9:0]  BAL_P_RESET   = 10'd170;
    localparam logic [9:0]  BAL_D_RESET   = 10'd170;
    localparam logic [9:0]  POS_P_RESET   = 10'd6;
    localparam logic [9:0]  POS_D_RESET   = 10'd160;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_SWING   = 2'd1;
    localparam logic [1:0] MODE_BALANCE = 2'd2;
    localparam logic [1:0] MODE_RECOVER = 2'd3;

    localparam logic [1:0] PHASE_KICK  = 2'd0;
    localparam logic [1:0] PHASE_PUMP  = 2'd1;
    localparam logic [1:0] PHASE_CATCH = 2'd2;

    localparam logic [15:0] ENC_KICK_MAX   = 16'd11000;
    localparam logic [15:0] ENC_PUMP_HIGH  = 16'd10500;
    localparam logic [15:0] ENC_PUMP_LOW   = 16'd9500;
    localparam logic [15:0] ENC_SWING_MAX  = 16'd12000;
    localparam logic [15:0] ENC_SWING_MIN  = 16'd8000;
    localparam logic [15:0] ENC_BAL_MAX    = 16'd11800;
    localparam logic [15:0] ENC_BAL_MIN    = 16'd8200;
    localparam logic [15:0] ENC_REC_LOW    = 16'd9000;
    localparam logic [15:0] ENC_REC_HIGH   = 16'd11000;

    localparam int DRIVE_LIMIT   = 6900;
    localparam int SWING_DRIVE   = 3000;
    localparam int RECOVER_DRIVE = 1300;
    localparam int SWING_OFFSET  = 2106;
    localparam int SWING_ERR     = 700;
    localparam int CATCH_ERR     = 100;
    localparam int TRIP_ERR      = 400;
    localparam int TRIP_RATE     = 100;
    localparam int REC_ERR       = 500;
    localparam int REC_RATE      = 60;
    localparam int POS_DIVISOR   = 5;
    localparam int POS_PERIOD    = 5;
    localparam int RATE_PERIOD   = 6;
    localparam int LONG_TICKS    = 80;

endpackage

// ===== rtl/psb_mul.sv =====
// ----------------------------------------------------------------------------
// Serial multiplier
// Signed operand times unsigned gain, one gain bit per cycle, shift and add.
// ----------------------------------------------------------------------------
module psb_mul #(
    parameter int AW = 35,
    parameter int BW = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [AW-1:0]        a,
    input  logic        [BW-1:0]        b,
    output logic                        done,
    output logic signed [AW+BW-1:0]     product
);

    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW + 1);

    logic                 busy_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 done_reg;
    logic signed [PW-1:0] acc_reg;
    logic signed [PW-1:0] a_reg;
    logic [BW-1:0]        b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(BW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= PW'(a);
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg <<< 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== rtl/psb_div.sv =====
// ----------------------------------------------------------------------------
// Serial constant divider
// Signed dividend over a constant divisor, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module psb_div #(
    parameter int W       = 37,
    parameter int DIVISOR = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [W-1:0] x,
    output logic                done,
    output logic signed [W-1:0] q
);

    localparam int RW = $clog2(DIVISOR + 1) + 1;
    localparam int CW = $clog2(W + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic          neg_reg;
    logic [W-1:0]  mag_reg;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] trial;
    logic          fits;

    assign trial = {rem_reg[RW-2:0], mag_reg[W-1]};
    assign fits  = (trial >= RW'(DIVISOR));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= x[W-1];
            mag_reg <= x[W-1] ? W'(-x) : W'(x);
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (trial - RW'(DIVISOR)) : trial;
            mag_reg <= {mag_reg[W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign q    = neg_reg ? $signed(W'(-mag_reg)) : $signed(mag_reg);

endmodule

// ===== rtl/pendulum_swingup_balance_controller.sv =====
// ----------------------------------------------------------------------------
// Pendulum swing-up and balance controller
// One beat per control tick in, one drive beat out, with mode handling.
// ----------------------------------------------------------------------------
// Usage: each control tick the host sends one beat of encoder count, angle
// sample and key level on the item channel (valid/ready). The block returns
// one beat on the result channel: drive direction, magnitude, a written flag
// and the mode after the tick. Items are worked one at a time by a sequencer
// around a shared serial multiplier (one gain bit per cycle) and
// two serial dividers (one quotient bit per cycle).
// A tick without arithmetic runs the sequencer steps only; every sixth tick
// the rate divider runs, in balance mode the multiplier forms the angle PD
// terms, and every fifth balance tick the position filter adds a divide and
// two multiplies. The next item is taken as soon as the sequencer is back in
// its idle state, even while the previous result still waits in the output
// register. If the receiver stalls with a result still held, the sequencer
// waits in its last step. Reset loads the register defaults and clears the
// control state, not the datapath. Configuration writes take effect at
// once; the user must make them between ticks, the block does not enforce it.
// ----------------------------------------------------------------------------
module pendulum_swingup_balance_controller #(
    parameter int RATE_TAPS = psb_pkg::RATE_TAPS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  logic [15:0]                     encoder_count,
    input  logic [11:0]                     angle_sample,
    input  logic                            key_down,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic                            drive_reverse,
    output logic [12:0]                     drive_magnitude,
    output logic                            drive_written,
    output logic [1:0]                      mode_now,
    input  logic                            cfg_write,
    input  logic [psb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [psb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int SUM_W = 13 + $clog2(RATE_TAPS) + 1;

    typedef enum logic [16:0] {
        ST_IDLE  = 17'b00000000000000001,
        ST_RATE  = 17'b00000000000000010,
        ST_RDIV  = 17'b00000000000000100,
        ST_SWING = 17'b00000000000001000,
        ST_BAL   = 17'b00000000000010000,
        ST_BM1   = 17'b00000000000100000,
        ST_BL2   = 17'b00000000001000000,
        ST_BM2   = 17'b00000000010000000,
        ST_PDIV  = 17'b00000000100000000,
        ST_PL1   = 17'b00000001000000000,
        ST_PM1   = 17'b00000010000000000,
        ST_PL2   = 17'b00000100000000000,
        ST_PM2   = 17'b00001000000000000,
        ST_BFIN  = 17'b00010000000000000,
        ST_REC   = 17'b00100000000000000,
        ST_KEY   = 17'b01000000000000000,
        ST_OUT   = 17'b10000000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [11:0] up_reg;
    logic [15:0] center_reg;
    logic [9:0]  bal_p_reg, bal_d_reg, pos_p_reg, pos_d_reg;

    logic [15:0] enc_reg;
    logic [11:0] ang_reg;
    logic        key_reg;

    logic [1:0]  mode_reg, mode_next;
    logic [1:0]  phase_reg, phase_next;
    logic [6:0]  ticks_reg, ticks_next;
    logic [7:0]  long_reg, long_next;
    logic [2:0]  pdiv_reg, pdiv_next;
    logic [2:0]  rdiv_reg, rdiv_next;
    logic [11:0] last_ang_reg, last_ang_next;
    logic signed [12:0] win_reg [RATE_TAPS];
    logic signed [12:0] win_next [RATE_TAPS];
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [12:0] rate_reg, rate_next;
    logic signed [12:0] last_err_reg, last_err_next;
    logic signed [33:0] f_reg, f_next;
    logic signed [33:0] last_f_reg, last_f_next;
    logic signed [34:0] diff_reg, diff_next;
    logic signed [27:0] pdrive_reg, pdrive_next;
    logic signed [44:0] acc_reg, acc_next;
    logic signed [24:0] bal_reg, bal_next;
    logic signed [13:0] moto_reg, moto_next;
    logic        written_reg, written_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_rev_reg;
    logic [12:0] out_mag_reg;
    logic        out_wr_reg;
    logic [1:0]  out_mode_reg;
    logic        out_load;

    logic signed [12:0] err;
    logic signed [13:0] swing_ref;
    logic signed [13:0] err_diff;
    logic signed [12:0] rate_diff;
    logic signed [16:0] least;
    logic signed [36:0] pos_num;
    logic signed [36:0] f_ext, l_ext;
    logic signed [45:0] psum;
    logic signed [45:0] psum_adj;
    logic signed [28:0] moto_wide;
    logic signed [13:0] moto_abs;

    logic               mul_start;
    logic signed [34:0] mul_a;
    logic [9:0]         mul_b;
    logic               mul_done;
    logic signed [44:0] mul_p;

    logic                    rdiv_start;
    logic                    rdiv_done;
    logic signed [SUM_W-1:0] rdiv_q;

    logic               pos_start;
    logic               pos_done;
    logic signed [36:0] pos_q;

    assign err       = $signed({1'b0, ang_reg} - {1'b0, up_reg});
    assign swing_ref = 14'(err) + 14'sd2106;
    assign err_diff  = 14'(err) - 14'(last_err_reg);
    assign rate_diff = $signed({1'b0, ang_reg} - {1'b0, last_ang_reg});
    assign least     = $signed({1'b0, enc_reg} - {1'b0, center_reg});
    assign f_ext     = 37'(f_reg);
    assign l_ext     = 37'(least);
    assign pos_num   = (f_ext <<< 2) + (l_ext <<< 16);
    assign psum      = 46'(acc_reg) + 46'(mul_p);
    assign psum_adj  = psum[45] ? (psum + 46'sd65535) : psum;
    assign moto_wide = 29'(bal_reg) - 29'(pdrive_reg);
    assign moto_abs  = moto_reg[13] ? -moto_reg : moto_reg;

    always_comb
    begin
        mul_a = 35'(err);
        mul_b = bal_p_reg;
        unique case (state_reg)
            ST_BL2:
            begin
                mul_a = 35'(err_diff);
                mul_b = bal_d_reg;
            end
            ST_PL1:
            begin
                mul_a = 35'(f_reg);
                mul_b = pos_p_reg;
            end
            ST_PL2:
            begin
                mul_a = diff_reg;
                mul_b = pos_d_reg;
            end
            default:
            begin
                mul_a = 35'(err);
                mul_b = bal_p_reg;
            end
        endcase
    end

    psb_mul #(
        .AW(35),
        .BW(10)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    psb_div #(
        .W      (SUM_W),
        .DIVISOR(RATE_TAPS)
    ) u_rate_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rdiv_start),
        .x     (sum_next),
        .done  (rdiv_done),
        .q     (rdiv_q)
    );

    psb_div #(
        .W      (37),
        .DIVISOR(psb_pkg::POS_DIVISOR)
    ) u_pos_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pos_start),
        .x     (pos_num),
        .done  (pos_done),
        .q     (pos_q)
    );

    assign item_ready = (state_reg == ST_IDLE);
    assign out_load   = (state_reg == ST_OUT) && (!out_valid_reg || result_ready);

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        phase_next     = phase_reg;
        ticks_next     = ticks_reg;
        long_next      = long_reg;
        pdiv_next      = pdiv_reg;
        rdiv_next      = rdiv_reg;
        last_ang_next  = last_ang_reg;
        win_next       = win_reg;
        sum_next       = sum_reg;
        rate_next      = rate_reg;
        last_err_next  = last_err_reg;
        f_next         = f_reg;
        last_f_next    = last_f_reg;
        diff_next      = diff_reg;
        pdrive_next    = pdrive_reg;
        acc_next       = acc_reg;
        bal_next       = bal_reg;
        moto_next      = moto_reg;
        written_next   = written_reg;
        mul_start      = 1'b0;
        rdiv_start     = 1'b0;
        pos_start      = 1'b0;
        out_valid_next = out_valid_reg && !result_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    moto_next    = '0;
                    written_next = 1'b0;
                    state_next   = ST_RATE;
                end
            end
            ST_RATE:
            begin
                if (rdiv_reg + 3'd1 >= 3'(psb_pkg::RATE_PERIOD))
                begin
                    for (int i = 0; i < RATE_TAPS - 1; i++)
                    begin
                        win_next[i] = win_reg[i + 1];
                    end
                    win_next[RATE_TAPS-1] = rate_diff;
                    sum_next      = sum_reg - SUM_W'(win_reg[0]) + SUM_W'(rate_diff);
                    rdiv_start    = 1'b1;
                    rdiv_next     = '0;
                    last_ang_next = ang_reg;
                    state_next    = ST_RDIV;
                end
                else
                begin
                    rdiv_next  = rdiv_reg + 3'd1;
                    state_next = ST_SWING;
                end
            end
            ST_RDIV:
            begin
                if (rdiv_done)
                begin
                    rate_next  = rdiv_q[12:0];
                    state_next = ST_SWING;
                end
            end
            ST_SWING:
            begin
                if (mode_reg == psb_pkg::MODE_SWING)
                begin
                    if (phase_reg == psb_pkg::PHASE_KICK && enc_reg <= psb_pkg::ENC_KICK_MAX)
                    begin
                        moto_next = -14'(psb_pkg::SWING_DRIVE);
                    end
                    else
                    begin
                        moto_next  = '0;
                        phase_next = psb_pkg::PHASE_PUMP;
                    end
                    if (phase_next == psb_pkg::PHASE_PUMP && enc_reg < psb_pkg::ENC_PUMP_HIGH
                        && (swing_ref < -14'sd2 || err > 13'(psb_pkg::SWING_ERR)))
                    begin
                        moto_next = -14'(psb_pkg::SWING_DRIVE);
                    end
                    else if (phase_next == psb_pkg::PHASE_PUMP
                        && enc_reg > psb_pkg::ENC_PUMP_LOW
                        && swing_ref > 14'sd2 && err < -13'(psb_pkg::SWING_ERR))
                    begin
                        moto_next = 14'(psb_pkg::SWING_DRIVE);
                    end
                    if (err < 13'(psb_pkg::CATCH_ERR) && err > -13'(psb_pkg::CATCH_ERR))
                    begin
                        phase_next = psb_pkg::PHASE_CATCH;
                        mode_next  = psb_pkg::MODE_BALANCE;
                    end
                    if (phase_next == psb_pkg::PHASE_CATCH)
                    begin
                        moto_next = '0;
                    end
                    if (enc_reg > psb_pkg::ENC_SWING_MAX || enc_reg < psb_pkg::ENC_SWING_MIN)
                    begin
                        moto_next = '0;
                    end
                    written_next = 1'b1;
                end
                state_next = ST_BAL;
            end
            ST_BAL:
            begin
                if (mode_reg == psb_pkg::MODE_BALANCE)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_BM1;
                end
                else
                begin
                    state_next = ST_REC;
                end
            end
            ST_BM1:
            begin
                if (mul_done)
                begin
                    acc_next   = mul_p;
                    state_next = ST_BL2;
                end
            end
            ST_BL2:
            begin
                mul_start  = 1'b1;
                state_next = ST_BM2;
            end
            ST_BM2:
            begin
                if (mul_done)
                begin
                    bal_next      = 25'(acc_reg) + 25'(mul_p);
                    last_err_next = err;
                    if (pdiv_reg + 3'd1 >= 3'(psb_pkg::POS_PERIOD))
                    begin
                        pdiv_next  = '0;
                        pos_start  = 1'b1;
                        state_next = ST_PDIV;
                    end
                    else
                    begin
                        pdiv_next  = pdiv_reg + 3'd1;
                        state_next = ST_BFIN;
                    end
                end
            end
            ST_PDIV:
            begin
                if (pos_done)
                begin
                    f_next      = pos_q[33:0];
                    last_f_next = pos_q[33:0];
                    diff_next   = 35'($signed(pos_q[33:0])) - 35'(last_f_reg);
                    state_next  = ST_PL1;
                end
            end
            ST_PL1:
            begin
                mul_start  = 1'b1;
                state_next = ST_PM1;
            end
            ST_PM1:
            begin
                if (mul_done)
                begin
                    acc_next   = mul_p;
                    state_next = ST_PL2;
                end
            end
            ST_PL2:
            begin
                mul_start  = 1'b1;
                state_next = ST_PM2;
            end
            ST_PM2:
            begin
                if (mul_done)
                begin
                    pdrive_next = psum_adj[43:16];
                    state_next  = ST_BFIN;
                end
            end
            ST_BFIN:
            begin
                if (moto_wide < -29'(psb_pkg::DRIVE_LIMIT))
                begin
                    moto_next = -14'(psb_pkg::DRIVE_LIMIT);
                end
                else if (moto_wide > 29'(psb_pkg::DRIVE_LIMIT))
                begin
                    moto_next = 14'(psb_pkg::DRIVE_LIMIT);
                end
                else
                begin
                    moto_next = moto_wide[13:0];
                end
                if (err > 13'(psb_pkg::TRIP_ERR) || err < -13'(psb_pkg::TRIP_ERR)
                    || rate_reg > 13'(psb_pkg::TRIP_RATE)
                    || rate_reg < -13'(psb_pkg::TRIP_RATE))
                begin
                    moto_next = '0;
                    mode_next = psb_pkg::MODE_RECOVER;
                end
                if (enc_reg > psb_pkg::ENC_BAL_MAX || enc_reg < psb_pkg::ENC_BAL_MIN)
                begin
                    moto_next = '0;
                    mode_next = psb_pkg::MODE_RECOVER;
                end
                written_next = 1'b1;
                state_next   = ST_REC;
            end
            ST_REC:
            begin
                if (mode_reg == psb_pkg::MODE_RECOVER)
                begin
                    if (err < 13'(psb_pkg::REC_ERR) && err > -13'(psb_pkg::REC_ERR)
                        && rate_reg < 13'(psb_pkg::REC_RATE)
                        && rate_reg > -13'(psb_pkg::REC_RATE))
                    begin
                        mode_next = psb_pkg::MODE_BALANCE;
                    end
                    if (enc_reg < psb_pkg::ENC_REC_LOW)
                    begin
                        moto_next = 14'(psb_pkg::RECOVER_DRIVE);
                    end
                    else if (enc_reg > psb_pkg::ENC_REC_HIGH)
                    begin
                        moto_next = -14'(psb_pkg::RECOVER_DRIVE);
                    end
                    else
                    begin
                        moto_next = '0;
                    end
                    written_next = 1'b1;
                end
                state_next = ST_KEY;
            end
            ST_KEY:
            begin
                if (key_reg || ticks_reg != 7'd0)
                begin
                    ticks_next = ticks_reg + 7'd1;
                    if (!key_reg && long_reg == 8'd0)
                    begin
                        ticks_next = '0;
                        mode_next  = psb_pkg::MODE_BALANCE;
                    end
                    if (ticks_next == 7'(psb_pkg::LONG_TICKS))
                    begin
                        ticks_next = '0;
                        if (long_reg != 8'hFF)
                        begin
                            long_next = long_reg + 8'd1;
                        end
                        if (!key_reg)
                        begin
                            long_next = '0;
                        end
                        mode_next = psb_pkg::MODE_SWING;
                    end
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg     <= psb_pkg::UPRIGHT_RESET;
            center_reg <= psb_pkg::CENTER_RESET;
            bal_p_reg  <= psb_pkg::BAL_P_RESET;
            bal_d_reg  <= psb_pkg::BAL_D_RESET;
            pos_p_reg  <= psb_pkg::POS_P_RESET;
            pos_d_reg  <= psb_pkg::POS_D_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                psb_pkg::CFG_UPRIGHT: up_reg     <= cfg_data[11:0];
                psb_pkg::CFG_CENTER:  center_reg <= cfg_data;
                psb_pkg::CFG_BAL_P:   bal_p_reg  <= cfg_data[9:0];
                psb_pkg::CFG_BAL_D:   bal_d_reg  <= cfg_data[9:0];
                psb_pkg::CFG_POS_P:   pos_p_reg  <= cfg_data[9:0];
                psb_pkg::CFG_POS_D:   pos_d_reg  <= cfg_data[9:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= psb_pkg::MODE_IDLE;
            phase_reg     <= psb_pkg::PHASE_KICK;
            ticks_reg     <= '0;
            long_reg      <= '0;
            pdiv_reg      <= '0;
            rdiv_reg      <= '0;
            last_ang_reg  <= '0;
            for (int i = 0; i < RATE_TAPS; i++)
            begin
                win_reg[i] <= '0;
            end
            sum_reg       <= '0;
            rate_reg      <= '0;
            last_err_reg  <= '0;
            f_reg         <= '0;
            last_f_reg    <= '0;
            diff_reg      <= '0;
            pdrive_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            phase_reg     <= phase_next;
            ticks_reg     <= ticks_next;
            long_reg      <= long_next;
            pdiv_reg      <= pdiv_next;
            rdiv_reg      <= rdiv_next;
            last_ang_reg  <= last_ang_next;
            win_reg       <= win_next;
            sum_reg       <= sum_next;
            rate_reg      <= rate_next;
            last_err_reg  <= last_err_next;
            f_reg         <= f_next;
            last_f_reg    <= last_f_next;
            diff_reg      <= diff_next;
            pdrive_reg    <= pdrive_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            enc_reg <= encoder_count;
            ang_reg <= angle_sample;
            key_reg <= key_down;
        end
        acc_reg     <= acc_next;
        bal_reg     <= bal_next;
        moto_reg    <= moto_next;
        written_reg <= written_next;
        if (out_load)
        begin
            out_rev_reg  <= written_reg && moto_reg[13];
            out_mag_reg  <= written_reg ? moto_abs[12:0] : 13'd0;
            out_wr_reg   <= written_reg;
            out_mode_reg <= mode_reg;
        end
    end

    assign result_valid    = out_valid_reg;
    assign drive_reverse   = out_rev_reg;
    assign drive_magnitude = out_mag_reg;
    assign drive_written   = out_wr_reg;
    assign mode_now        = out_mode_reg;

`ifndef SYNTHESIS
    a_mag_limit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (drive_magnitude <= 13'(psb_pkg::DRIVE_LIMIT)))
        else $error("Drive magnitude exceeds the clamp limit.");

    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !drive_written) |-> (drive_magnitude == 13'd0 && !drive_reverse))
        else $error("A beat without a drive write carries a drive value.");

    a_ticks_range: assert property (@(posedge clk) disable iff (!rst_n)
        ticks_reg < 7'(psb_pkg::LONG_TICKS))
        else $error("Key tick counter passed the long press length.");

    a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_BM1 || state_reg == ST_BM2
            || state_reg == ST_PM1 || state_reg == ST_PM2))
        else $error("Multiplier finished outside a wait step.");
`endif

endmodule

// ===== verif/pendulum_swingup_balance_controller_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pendulum controller testbench
// Sends control ticks with random gaps, takes drive beats with random stalls
// and checks every beat against a cycle-free model of the controller kept in
// this file or a typed table row. A directed table runs first, then key-press
// episodes with near-upright and noisy samples under several register settings.
// ----------------------------------------------------------------------------
module pendulum_swingup_balance_controller_tb;
    import psb_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 150;

    typedef struct packed {
        logic        rev;
        logic [12:0] mag;
        logic        wr;
        logic [1:0]  mode;
    } drive_t;

    typedef struct {
        logic [15:0] enc;
        logic [11:0] ang;
        logic        key;
        bit          typed;
        drive_t      want;
    } tick_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_ready;
    logic [15:0]           encoder_count = '0;
    logic [11:0]           angle_sample = '0;
    logic                  key_down = 1'b0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    logic                  drive_reverse;
    logic [12:0]           drive_magnitude;
    logic                  drive_written;
    logic [1:0]            mode_now;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    drive_t drive_queue[$];
    int     error_count = 0;
    int     cycle_count = 0;
    bit     calm = 1'b0;

    // Model state.
    int          m_up, m_center, m_bal_p, m_bal_d, m_pos_p, m_pos_d;
    logic [1:0]  m_mode, m_phase;
    int          m_key_ticks, m_long_count, m_pos_div, m_rate_div, m_rate_last;
    shortint     m_window[RATE_TAPS_DEFAULT];
    int          m_rate, m_last_err, m_pos_drive;
    longint      m_filt, m_filt_last;

    pendulum_swingup_balance_controller i_dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready),
        .encoder_count(encoder_count), .angle_sample(angle_sample), .key_down(key_down),
        .result_valid(result_valid), .result_ready(result_ready),
        .drive_reverse(drive_reverse), .drive_magnitude(drive_magnitude),
        .drive_written(drive_written), .mode_now(mode_now),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    function automatic drive_t control_tick(int enc, int ang, bit key);
        int     err;
        int     sum;
        longint moto;
        longint bal;
        longint least;
        longint diff;
        bit     written;
        drive_t r;
        err = ang - m_up;
        moto = 0;
        written = 1'b0;

        m_rate_div++;
        if (m_rate_div > 5)
        begin
            sum = 0;
            for (int i = 1; i < RATE_TAPS_DEFAULT; i++)
                m_window[i-1] = m_window[i];
            m_window[RATE_TAPS_DEFAULT-1] = shortint'(ang - m_rate_last);
            for (int i = 0; i < RATE_TAPS_DEFAULT; i++)
                sum += m_window[i];
            m_rate = sum / RATE_TAPS_DEFAULT;
            m_rate_last = ang;
            m_rate_div = 0;
        end

        if (m_mode == MODE_SWING)
        begin
            if (m_phase == PHASE_KICK && enc <= 11000)
                moto = -3000;
            else
            begin
                moto = 0;
                m_phase = PHASE_PUMP;
            end
            if (m_phase == PHASE_PUMP && enc < 10500 &&
                ((m_up - 2106) - ang > 2 || err > 700))
                moto = -3000;
            else if (m_phase == PHASE_PUMP && enc > 9500 &&
                     ang - (m_up - 2106) > 2 && err < -700)
                moto = 3000;
            if (err < 100 && err > -100)
            begin
                m_phase = PHASE_CATCH;
                m_mode = MODE_BALANCE;
            end
            if (m_phase == PHASE_CATCH)
                moto = 0;
            if (enc > 12000 || enc < 8000)
                moto = 0;
            written = 1'b1;
        end

        if (m_mode == MODE_BALANCE)
        begin
            bal = longint'(err) * m_bal_p + longint'(err - m_last_err) * m_bal_d;
            m_last_err = err;
            m_pos_div++;
            if (m_pos_div > 4)
            begin
                least = longint'(enc) - m_center;
                m_filt = (4 * m_filt + least * 65536) / 5;
                diff = m_filt - m_filt_last;
                m_filt_last = m_filt;
                m_pos_drive = int'((m_filt * m_pos_p + diff * m_pos_d) / 65536);
                m_pos_div = 0;
            end
            moto = bal - m_pos_drive;
            if (moto < -DRIVE_LIMIT)
                moto = -DRIVE_LIMIT;
            if (moto > DRIVE_LIMIT)
                moto = DRIVE_LIMIT;
            if (err > 400 || err < -400 || m_rate > 100 || m_rate < -100)
            begin
                moto = 0;
                m_mode = MODE_RECOVER;
            end
            if (enc > 11800 || enc < 8200)
            begin
                moto = 0;
                m_mode = MODE_RECOVER;
            end
            written = 1'b1;
        end

        if (m_mode == MODE_RECOVER)
        begin
            if (err < 500 && err > -500 && m_rate < 60 && m_rate > -60)
                m_mode = MODE_BALANCE;
            if (enc < 9000)
                moto = 1300;
            else if (enc > 11000)
                moto = -1300;
            else
                moto = 0;
            written = 1'b1;
        end

        if (key || m_key_ticks != 0)
        begin
            m_key_ticks++;
            if (!key && m_long_count == 0)
            begin
                m_key_ticks = 0;
                m_mode = MODE_BALANCE;
            end
            if (m_key_ticks == 80)
            begin
                m_key_ticks = 0;
                if (m_long_count < 255)
                    m_long_count++;
                if (!key)
                    m_long_count = 0;
                m_mode = MODE_SWING;
            end
        end

        r.rev = written && moto < 0;
        r.mag = written ? 13'(moto < 0 ? -moto : moto) : '0;
        r.wr = written;
        r.mode = m_mode;
        return r;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_UPRIGHT: m_up = value & 'hFFF;
            CFG_CENTER:  m_center = value & 'hFFFF;
            CFG_BAL_P:   m_bal_p = value & 'h3FF;
            CFG_BAL_D:   m_bal_d = value & 'h3FF;
            CFG_POS_P:   m_pos_p = value & 'h3FF;
            CFG_POS_D:   m_pos_d = value & 'h3FF;
            default: ;
        endcase
    endtask

    task automatic set_gains(int up, int center, int bp, int bd, int pp, int pd);
        write_reg(CFG_UPRIGHT, up);
        write_reg(CFG_CENTER, center);
        write_reg(CFG_BAL_P, bp);
        write_reg(CFG_BAL_D, bd);
        write_reg(CFG_POS_P, pp);
        write_reg(CFG_POS_D, pd);
    endtask

    // Called right after an edge; returns right after the accepting edge.
    task automatic send_tick(int enc, int ang, bit key, bit typed, drive_t want);
        drive_t predicted;
        if (!calm && $urandom_range(0, 99) < 23)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        item_valid <= 1'b1;
        encoder_count <= 16'(enc);
        angle_sample <= 12'(ang);
        key_down <= key;
        do
            @(posedge clk);
        while (!item_ready);
        predicted = control_tick(enc, ang, key);
        drive_queue.push_back(typed ? want : predicted);
    endtask

    // Called right after the last accepting edge.
    task automatic drain;
        item_valid <= 1'b0;
        while (drive_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic int near_upright();
        int a;
        a = m_up + $urandom_range(0, 1200) - 600;
        return a < 0 ? 0 : (a > 4095 ? 4095 : a);
    endfunction

    task automatic shaped_tick(bit key);
        int enc;
        int ang;
        case ($urandom_range(0, 9))
            0, 1:    enc = $urandom_range(0, 65535);
            2, 3:    enc = $urandom_range(7500, 12500);
            default: enc = $urandom_range(9200, 10800);
        endcase
        case ($urandom_range(0, 9))
            0:       ang = $urandom_range(0, 4095);
            1, 2:    ang = $urandom_range(0, 4095) & 'hF00 | m_up & 'h0FF;
            default: ang = near_upright();
        endcase
        send_tick(enc, ang, key, 1'b0, '0);
    endtask

    task automatic random_phase(int target);
        int sent;
        int held;
        sent = 0;
        while (sent < target)
        begin
            case ($urandom_range(0, 3))
                0: held = $urandom_range(1, 3);
                1: held = $urandom_range(80, 86);
                2: held = $urandom_range(160, 166);
                default: held = 0;
            endcase
            for (int i = 0; i < held && sent < target; i++)
            begin
                shaped_tick(1'b1);
                sent++;
            end
            for (int i = 0; i < 40 && sent < target; i++)
            begin
                shaped_tick($urandom_range(0, 49) == 0);
                sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        drive_t got;
        drive_t want;
        if (rst_n && result_valid && result_ready)
        begin
            got = '{drive_reverse, drive_magnitude, drive_written, mode_now};
            if (drive_queue.size() == 0)
            begin
                $error("unexpected drive beat %p", got);
                error_count++;
            end
            else
            begin
                want = drive_queue.pop_front();
                if (got.rev !== want.rev)
                begin
                    $error("drive_reverse: expected %0d, got %0d", want.rev, got.rev);
                    error_count++;
                end
                if (got.mag !== want.mag)
                begin
                    $error("drive_magnitude: expected %0d, got %0d", want.mag, got.mag);
                    error_count++;
                end
                if (got.wr !== want.wr)
                begin
                    $error("drive_written: expected %0d, got %0d", want.wr, got.wr);
                    error_count++;
                end
                if (got.mode !== want.mode)
                begin
                    $error("mode_now: expected %0d, got %0d", want.mode, got.mode);
                    error_count++;
                end
            end
        end
        result_ready <= calm || $urandom_range(0, 99) >= 23;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        tick_row_t rows[$];
        drive_t    quiet;
        drive_t    armed;
        quiet = '{1'b0, 13'd0, 1'b0, MODE_IDLE};
        armed = '{1'b0, 13'd0, 1'b0, MODE_BALANCE};
        rows = '{
            '{16'd0,     12'd0,    1'b0, 1'b1, quiet},
            '{16'd65535, 12'd4095, 1'b0, 1'b1, quiet},
            '{16'd10000, 12'd3100, 1'b1, 1'b1, quiet},
            '{16'd10000, 12'd3100, 1'b0, 1'b1, armed},
            '{16'd10000, 12'd3100, 1'b0, 1'b0, quiet},
            '{16'd10000, 12'd3150, 1'b0, 1'b0, quiet},
            '{16'd10000, 12'd3050, 1'b0, 1'b0, quiet},
            '{16'd10300, 12'd3110, 1'b0, 1'b0, quiet},
            '{16'd10000, 12'd3700, 1'b0, 1'b0, quiet},
            '{16'd7000,  12'd3700, 1'b0, 1'b0, quiet},
            '{16'd12500, 12'd3700, 1'b0, 1'b0, quiet},
            '{16'd10000, 12'd3100, 1'b0, 1'b0, quiet},
            '{16'd8100,  12'd3100, 1'b0, 1'b0, quiet},
            '{16'd11900, 12'd2600, 1'b0, 1'b0, quiet},
            '{16'd10000, 12'd0,    1'b0, 1'b0, quiet},
            '{16'd10000, 12'd4095, 1'b0, 1'b0, quiet},
            '{16'd10000, 12'd3100, 1'b1, 1'b0, quiet},
            '{16'd10000, 12'd3100, 1'b0, 1'b0, quiet}
        };

        m_up = UPRIGHT_RESET;
        m_center = CENTER_RESET;
        m_bal_p = BAL_P_RESET;
        m_bal_d = BAL_D_RESET;
        m_pos_p = POS_P_RESET;
        m_pos_d = POS_D_RESET;
        m_mode = MODE_IDLE;
        m_phase = PHASE_KICK;
        m_key_ticks = 0;
        m_long_count = 0;
        m_pos_div = 0;
        m_rate_div = 0;
        m_rate_last = 0;
        m_rate = 0;
        m_last_err = 0;
        m_pos_drive = 0;
        m_filt = 0;
        m_filt_last = 0;
        foreach (m_window[i])
            m_window[i] = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_tick(rows[i].enc, rows[i].ang, rows[i].key, rows[i].typed, rows[i].want);
        random_phase(130);
        drain();

        set_gains(4095, 65535, 1023, 1023, 1023, 1023);
        write_reg(3'd6, 'hFFFF);
        write_reg(3'd7, 0);
        calm = 1'b1;
        random_phase(100);
        calm = 1'b0;
        drain();

        set_gains(0, 0, 0, 0, 0, 0);
        random_phase(100);
        drain();

        set_gains(3100, 10000, 30, 400, 20, 500);
        random_phase(160);
        drain();

        set_gains($urandom_range(1500, 3500), $urandom_range(9000, 11000),
                  $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), $urandom_range(0, 1023));
        random_phase(160);
        drain();

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
